// ----- rtl/core/dmbc_pkg.sv -----
// shared types and constants for the direct-mapped block cache controller
package dmbc_pkg;

    localparam int BLOCK_W   = 32;
    localparam int SLOT_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int MOD_BYTES = BLOCK_W / BYTE_W;

    typedef logic [1:0] t_code;

    localparam t_code FUNC_MARK = 2'd0;
    localparam t_code FUNC_MOVE = 2'd1;
    localparam t_code FUNC_SYNC = 2'd2;

    localparam t_code CMD_WB    = 2'd0;
    localparam t_code CMD_FETCH = 2'd1;
    localparam t_code CMD_DONE  = 2'd2;

    typedef struct packed {
        logic              valid;
        t_code             cmd;
        logic [BLOCK_W-1:0] block_no;
        logic [SLOT_W-1:0]  slot;
        logic              last;
    } t_result;

endpackage

// ----- rtl/core/direct_mapped_block_cache_ctrl.sv -----
// direct-mapped block cache tag and dirty controller, top level
// one item at a time; mark or unknown func: reads the window tag and emits a done item
// sync: scans the dirty bit of every slot, writes back each dirty slot, then emits a done item
// move: a window hit goes on to the done item; a miss writes back dirty slots, then fetches on a tag miss
// an output item that waits on i_ready stalls the controller
// reset clears valid, dirty and window state at once; tag ram contents are gated by valid bits
module direct_mapped_block_cache_ctrl
    import dmbc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [BLOCK_W-1:0] i_block,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_cmd,
    output logic [BLOCK_W-1:0] o_block_no,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_last
);

    localparam int SW = $clog2(SLOTS);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_HIT_CHK = 4'd1;
    localparam logic [3:0] ST_FL_INIT = 4'd2;
    localparam logic [3:0] ST_FL_SCAN = 4'd3;
    localparam logic [3:0] ST_FL_EMIT = 4'd4;
    localparam logic [3:0] ST_MV_RD   = 4'd5;
    localparam logic [3:0] ST_MV_CHK  = 4'd6;
    localparam logic [3:0] ST_DN_RD   = 4'd7;
    localparam logic [3:0] ST_DN_EMIT = 4'd8;

    logic [3:0]         r_state, n_state;
    t_code              r_func, n_func;
    logic [BLOCK_W-1:0] r_blk, n_blk;
    logic [SW-1:0]      r_idx, n_idx;
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [SLOTS-1:0]   r_dirty, n_dirty;
    logic [SW-1:0]      r_wslot, n_wslot;
    logic               r_wvalid, n_wvalid;
    logic               r_wmod, n_wmod;
    t_result            r_out, n_out;

    logic               accept;
    logic               can_emit;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [SW-1:0]      ram_rd_addr;
    logic [BLOCK_W-1:0] ram_rd_data;
    logic               mod_start;
    logic               mod_done;
    logic [SW-1:0]      mod_rem;
    logic               scan_end;
    logic               miss;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign can_emit = !r_out.valid || i_ready;
    assign mod_start = accept && (i_func == FUNC_MOVE);
    assign scan_end = (r_idx == SW'(SLOTS-1));
    assign miss     = !r_valid[mod_rem] || (ram_rd_data != r_blk);

    dmbc_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (mod_rem),
        .i_wr_data (r_blk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    dmbc_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_block (i_block),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_blk      = r_blk;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_dirty    = r_dirty;
        n_wslot    = r_wslot;
        n_wvalid   = r_wvalid;
        n_wmod     = r_wmod;
        n_out      = r_out;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        ram_rd_addr = r_wslot;

        if (i_ready) begin
            n_out.valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_blk  = i_block;
                    case (i_func)
                        FUNC_MARK: begin
                            if (r_wvalid) begin
                                n_wmod = 1'b1;
                            end
                            n_state = ST_DN_RD;
                        end
                        FUNC_MOVE: begin
                            ram_rd_en = 1'b1;
                            n_state   = ST_HIT_CHK;
                        end
                        FUNC_SYNC: begin
                            n_state = ST_FL_INIT;
                        end
                        default: begin
                            n_state = ST_DN_RD;
                        end
                    endcase
                end
            end
            ST_HIT_CHK: begin
                if (r_wvalid && r_valid[r_wslot] && (ram_rd_data == r_blk)) begin
                    n_state = ST_DN_RD;
                end else begin
                    n_state = ST_FL_INIT;
                end
            end
            ST_FL_INIT: begin
                if (r_wmod) begin
                    n_dirty[r_wslot] = 1'b1;
                end
                n_wmod  = 1'b0;
                n_idx   = '0;
                n_state = ST_FL_SCAN;
            end
            ST_FL_SCAN: begin
                if (r_dirty[r_idx]) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_idx;
                    n_state     = ST_FL_EMIT;
                end else if (scan_end) begin
                    n_state = (r_func == FUNC_MOVE) ? ST_MV_RD : ST_DN_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FL_EMIT: begin
                if (can_emit) begin
                    n_out.valid    = 1'b1;
                    n_out.cmd      = CMD_WB;
                    n_out.block_no = ram_rd_data;
                    n_out.slot     = SLOT_W'(r_idx);
                    n_out.last     = 1'b0;
                    n_dirty[r_idx] = 1'b0;
                    if (scan_end) begin
                        n_state = (r_func == FUNC_MOVE) ? ST_MV_RD : ST_DN_RD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_FL_SCAN;
                    end
                end
            end
            ST_MV_RD: begin
                if (mod_done) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mod_rem;
                    n_state     = ST_MV_CHK;
                end
            end
            ST_MV_CHK: begin
                if (!miss || can_emit) begin
                    if (miss) begin
                        n_out.valid      = 1'b1;
                        n_out.cmd        = CMD_FETCH;
                        n_out.block_no   = r_blk;
                        n_out.slot       = SLOT_W'(mod_rem);
                        n_out.last       = 1'b0;
                        ram_wr_en        = 1'b1;
                        n_valid[mod_rem] = 1'b1;
                    end
                    n_wslot  = mod_rem;
                    n_wvalid = 1'b1;
                    n_state  = ST_DN_RD;
                end
            end
            ST_DN_RD: begin
                ram_rd_en = 1'b1;
                n_state   = ST_DN_EMIT;
            end
            ST_DN_EMIT: begin
                if (can_emit) begin
                    n_out.valid    = 1'b1;
                    n_out.cmd      = CMD_DONE;
                    n_out.block_no = (r_wvalid && r_valid[r_wslot]) ? ram_rd_data : '0;
                    n_out.slot     = SLOT_W'(r_wslot);
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_wslot     <= '0;
            r_wvalid    <= 1'b0;
            r_wmod      <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_wslot     <= n_wslot;
            r_wvalid    <= n_wvalid;
            r_wmod      <= n_wmod;
            r_out.valid <= n_out.valid;
        end
        r_func           <= n_func;
        r_blk            <= n_blk;
        r_idx            <= n_idx;
        r_out.cmd        <= n_out.cmd;
        r_out.block_no   <= n_out.block_no;
        r_out.slot       <= n_out.slot;
        r_out.last       <= n_out.last;
    end

    assign o_valid    = r_out.valid;
    assign o_cmd      = r_out.cmd;
    assign o_block_no = r_out.block_no;
    assign o_slot     = r_out.slot;
    assign o_last     = r_out.last;

    property p_mod_ready;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == ST_MV_CHK) |-> mod_done;
    endproperty
    a_mod_ready: assert property (p_mod_ready) else $error("slot check without remainder");

    property p_mark_window;
        @(posedge i_clk) disable iff (!i_rst_n) r_wmod |-> r_wvalid;
    endproperty
    a_mark_window: assert property (p_mark_window) else $error("mark pending with no window");

    property p_window_stays;
        @(posedge i_clk) disable iff (!i_rst_n) !$fell(r_wvalid);
    endproperty
    a_window_stays: assert property (p_window_stays) else $error("window lost");

    property p_window_slot_valid;
        @(posedge i_clk) disable iff (!i_rst_n) r_wvalid |-> r_valid[r_wslot];
    endproperty
    a_window_slot_valid: assert property (p_window_slot_valid) else $error("window on empty slot");

    property p_last_done;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> (o_last == (o_cmd == CMD_DONE));
    endproperty
    a_last_done: assert property (p_last_done) else $error("last flag mismatch");

endmodule

// ----- rtl/core/dmbc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module dmbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/dmbc_mod.sv -----
// block number modulo slot count from per-byte residue tables; the residue sum is registered, then reduced
module dmbc_mod
    import dmbc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [BLOCK_W-1:0]       i_block,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_rem
);

    localparam int SW = $clog2(SLOTS);

    logic [SW-1:0]     byte_res [MOD_BYTES][256];
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] r_sum;
    logic [SW-1:0]     r_rem;
    logic              r_busy;
    logic              r_done;

    // residue of each byte value weighted by its position
    for (genvar g = 0; g < MOD_BYTES; g++) begin : g_byte
        for (genvar v = 0; v < 256; v++) begin : g_val
            assign byte_res[g][v] = SW'((v * ((1 << (BYTE_W * g)) % SLOTS)) % SLOTS);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < MOD_BYTES; k++) begin
            n_sum = n_sum + BYTE_W'(byte_res[k][i_block[BYTE_W*k +: BYTE_W]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_sum  <= n_sum;
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
            r_rem  <= byte_res[0][r_sum];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("mod done while busy");

    property p_rem_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> (32'(r_rem) < SLOTS);
    endproperty
    a_rem_range: assert property (p_rem_range) else $error("remainder out of range");

    property p_busy_span;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_done) |-> $past(r_busy);
    endproperty
    a_busy_span: assert property (p_busy_span) else $error("done without run");

endmodule

// ----- dv/direct_mapped_block_cache_ctrl_test.sv -----
// self-checking testbench for the block cache controller: write-back, fetch and done items
module direct_mapped_block_cache_ctrl_test;
    import dmbc_pkg::*;

    localparam int    SLOTS       = 16;
    localparam t_code FUNC_UNUSED = 2'd3;

    typedef struct packed {
        t_code              cmd;
        logic [BLOCK_W-1:0] block_no;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } cache_cmd_t;

    class cache_cmd_scoreboard;
        cache_cmd_t         pending_cmds[$];
        logic [BLOCK_W-1:0] tag_mem[SLOTS];
        bit                 valid_bits[SLOTS];
        bit                 dirty_bits[SLOTS];
        logic [SLOT_W-1:0]  win_slot;
        bit                 win_valid;
        bit                 win_modified;
        int                 errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tag_mem[i]    = '0;
                valid_bits[i] = 1'b0;
                dirty_bits[i] = 1'b0;
            end
            win_slot     = '0;
            win_valid    = 1'b0;
            win_modified = 1'b0;
            errors       = 0;
        endfunction

        function void push_cmd(t_code c, logic [BLOCK_W-1:0] b, logic [SLOT_W-1:0] s,
                               logic l);
            cache_cmd_t e;
            e.cmd      = c;
            e.block_no = b;
            e.slot     = s;
            e.last     = l;
            pending_cmds.push_back(e);
        endfunction

        function void write_back_dirty();
            if (win_modified && win_valid) dirty_bits[win_slot] = 1'b1;
            win_modified = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (dirty_bits[i]) begin
                    push_cmd(CMD_WB, tag_mem[i], SLOT_W'(i), 1'b0);
                    dirty_bits[i] = 1'b0;
                end
            end
        endfunction

        function void note_item(t_code f, logic [BLOCK_W-1:0] b);
            bit                 hit;
            logic [SLOT_W-1:0]  dst;
            logic [BLOCK_W-1:0] wblk;
            case (f)
                FUNC_MARK: begin
                    if (win_valid) win_modified = 1'b1;
                end
                FUNC_SYNC: begin
                    write_back_dirty();
                end
                FUNC_MOVE: begin
                    hit = win_valid && valid_bits[win_slot] && tag_mem[win_slot] == b;
                    if (!hit) begin
                        write_back_dirty();
                        dst = SLOT_W'(b % SLOTS);
                        if (!valid_bits[dst] || tag_mem[dst] != b) begin
                            push_cmd(CMD_FETCH, b, dst, 1'b0);
                            tag_mem[dst]    = b;
                            valid_bits[dst] = 1'b1;
                        end
                        win_slot  = dst;
                        win_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            wblk = (win_valid && valid_bits[win_slot]) ? tag_mem[win_slot] : '0;
            push_cmd(CMD_DONE, wblk, win_slot, 1'b1);
        endfunction

        function void check_result(cache_cmd_t got);
            cache_cmd_t exp;
            if (pending_cmds.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: cmd %0d block %h slot %0d last %0b",
                             got.cmd, got.block_no, got.slot, got.last);
                return;
            end
            exp = pending_cmds.pop_front();
            if (got.cmd !== exp.cmd || got.block_no !== exp.block_no ||
                got.slot !== exp.slot || got.last !== exp.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp cmd %0d block %h slot %0d last %0b",
                             exp.cmd, exp.block_no, exp.slot, exp.last,
                             ", got cmd %0d block %h slot %0d last %0b",
                             got.cmd, got.block_no, got.slot, got.last);
            end
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [BLOCK_W-1:0] i_block;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_cmd;
    logic [BLOCK_W-1:0] o_block_no;
    logic [SLOT_W-1:0]  o_slot;
    logic               o_last;

    cache_cmd_scoreboard sb;
    bit                  idle_on;
    int                  rx_hold_req;
    logic [27:0]         hi_pool[4];

    direct_mapped_block_cache_ctrl #(.SLOTS(SLOTS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_block    (i_block),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cmd      (o_cmd),
        .o_block_no (o_block_no),
        .o_slot     (o_slot),
        .o_last     (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_code f, input logic [BLOCK_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_block <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(f, b);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // receiver side
    initial begin : rx_proc
        int         gap;
        cache_cmd_t got;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got.cmd      = o_cmd;
            got.block_no = o_block_no;
            got.slot     = o_slot;
            got.last     = o_last;
            sb.check_result(got);
        end
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : main_proc
        int                 r;
        t_code              f;
        logic [BLOCK_W-1:0] b;
        sb          = new();
        idle_on     = 1'b1;
        rx_hold_req = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func  <= FUNC_MARK;
        i_block <= '0;
        hi_pool[0] = '0;
        hi_pool[1] = 28'($urandom);
        hi_pool[2] = 28'($urandom);
        hi_pool[3] = '1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_item(FUNC_MARK, 32'h0);          // mark without window
        send_item(FUNC_UNUSED, 32'h0);
        send_item(FUNC_SYNC, 32'h0);
        send_item(FUNC_MOVE, 32'h0);
        send_item(FUNC_MOVE, 32'h0);          // window hit
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_UNUSED, 32'h12345678);
        send_item(FUNC_SYNC, 32'h0);
        send_item(FUNC_SYNC, 32'h0);
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_MOVE, 32'h10);         // same slot, other tag
        send_item(FUNC_MOVE, 32'hFFFF_FFFF);
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_MOVE, 32'hFFFF_FFFF);
        send_item(FUNC_MOVE, 32'h0000_000F);
        send_item(FUNC_MOVE, 32'h10);         // tag hit, window moves
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_MOVE, 32'hAAAA_AAAA);
        send_item(FUNC_MOVE, 32'h5555_5555);
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_MARK, 32'h0);
        send_item(FUNC_SYNC, 32'h0);
        send_item(FUNC_MOVE, 32'h8000_0000);
        send_item(FUNC_MOVE, 32'h7FFF_FFFF);
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
        wait_drained();

        // random part
        for (int i = 0; i < 500; i++) begin
            idle_on = ((i / 80) % 3) != 1;
            if (i == 150) rx_hold_req = 300;
            if (i == 250 || i == 400) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 55) begin
                f = FUNC_MOVE;
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 3) == 0)
                        b = {hi_pool[$urandom_range(0, 3)], 4'($urandom)};
                    else
                        b = {hi_pool[$urandom_range(0, 3)], 4'($urandom_range(0, 3))};
                end else begin
                    b = $urandom;
                end
            end else if (r < 80) begin
                f = FUNC_MARK;
                b = $urandom;
            end else if (r < 92) begin
                f = FUNC_SYNC;
                b = $urandom;
            end else begin
                f = FUNC_UNUSED;
                b = $urandom;
            end
            send_item(f, b);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dmbc_pkg.sv
rtl/core/dmbc_ram.sv
rtl/core/dmbc_mod.sv
rtl/core/direct_mapped_block_cache_ctrl.sv
dv/direct_mapped_block_cache_ctrl_test.sv
